### hdl/pcs_pkg.sv
// ----------------------------------------------------------------------------
// Path corner segmenter package
// Shared widths, word types and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
`default_nettype none

package pcs_pkg;

	localparam int COORD_BITS   = 24;
	localparam int ANGLE_BITS   = 16;
	localparam int SEGMENT_BITS = 16;
	localparam int THRESH_BITS  = 15;
	localparam logic [THRESH_BITS-1:0] THRESH_RESET = THRESH_BITS'(10923);

	localparam int CORDIC_STEPS = 28;
	localparam int STEP_BITS    = $clog2(CORDIC_STEPS);
	localparam int GUARD_SHIFT  = 8;
	localparam int ACC_BITS     = 32;
	// difference, guard shift, negation and CORDIC growth
	localparam int DIFF_BITS    = COORD_BITS + 1;
	localparam int DP_BITS      = DIFF_BITS + GUARD_SHIFT + 3;
	localparam int CMP_BITS     = (ANGLE_BITS > THRESH_BITS) ? ANGLE_BITS : THRESH_BITS;

	localparam logic [ACC_BITS-1:0] HALF_TURN = ACC_BITS'(1) << (ACC_BITS - 1);
	localparam logic [ACC_BITS-1:0] ROUND_ADD = ACC_BITS'(1) << (ACC_BITS - 1 - ANGLE_BITS);

	typedef struct packed {
		logic signed [COORD_BITS-1:0] point_x;
		logic signed [COORD_BITS-1:0] point_y;
		logic                         final_point;
	} in_word_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] out_x;
		logic signed [COORD_BITS-1:0] out_y;
		logic [SEGMENT_BITS-1:0]      segment_index;
		logic                         ends_segment;
		logic                         path_done;
		logic                         run_last;
	} out_word_t;

	// pair of points after the difference stage
	typedef struct packed {
		logic signed [COORD_BITS-1:0] emit_x;
		logic signed [COORD_BITS-1:0] emit_y;
		logic signed [COORD_BITS-1:0] new_x;
		logic signed [COORD_BITS-1:0] new_y;
		logic                         first;
		logic                         fin;
		logic signed [DIFF_BITS-1:0]  dx;
		logic signed [DIFF_BITS-1:0]  dy;
	} front_t;

	// pair of points travelling through the CORDIC cells
	typedef struct packed {
		logic signed [COORD_BITS-1:0] emit_x;
		logic signed [COORD_BITS-1:0] emit_y;
		logic signed [COORD_BITS-1:0] new_x;
		logic signed [COORD_BITS-1:0] new_y;
		logic                         first;
		logic                         fin;
		logic                         zero;
		logic signed [DP_BITS-1:0]    cx;
		logic signed [DP_BITS-1:0]    cy;
		logic [ACC_BITS-1:0]          cz;
	} cord_t;

	// pair of points with the rounded outgoing heading
	typedef struct packed {
		logic signed [COORD_BITS-1:0] emit_x;
		logic signed [COORD_BITS-1:0] emit_y;
		logic signed [COORD_BITS-1:0] new_x;
		logic signed [COORD_BITS-1:0] new_y;
		logic                         first;
		logic                         fin;
		logic [ANGLE_BITS-1:0]        heading;
	} hdg_t;

	typedef struct packed {
		logic take;
		logic pend_valid;
	} emit_status_t;

	function automatic logic [ACC_BITS-1:0] atan_entry(input logic [STEP_BITS-1:0] step);
		logic [ACC_BITS-1:0] v;
		case (step)
			5'd0:    v = 32'h20000000;
			5'd1:    v = 32'h12E4051E;
			5'd2:    v = 32'h09FB385B;
			5'd3:    v = 32'h051111D4;
			5'd4:    v = 32'h028B0D43;
			5'd5:    v = 32'h0145D7E1;
			5'd6:    v = 32'h00A2F61E;
			5'd7:    v = 32'h00517C55;
			5'd8:    v = 32'h0028BE53;
			5'd9:    v = 32'h00145F2F;
			5'd10:   v = 32'h000A2F98;
			5'd11:   v = 32'h000517CC;
			5'd12:   v = 32'h00028BE6;
			5'd13:   v = 32'h000145F3;
			5'd14:   v = 32'h0000A2FA;
			5'd15:   v = 32'h0000517D;
			5'd16:   v = 32'h000028BE;
			5'd17:   v = 32'h0000145F;
			5'd18:   v = 32'h00000A30;
			5'd19:   v = 32'h00000518;
			5'd20:   v = 32'h0000028C;
			5'd21:   v = 32'h00000146;
			5'd22:   v = 32'h000000A3;
			5'd23:   v = 32'h00000051;
			5'd24:   v = 32'h00000029;
			5'd25:   v = 32'h00000014;
			5'd26:   v = 32'h0000000A;
			5'd27:   v = 32'h00000005;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

### hdl/pcs_front.sv
// ----------------------------------------------------------------------------
// Path corner segmenter front end
// Holds the previous waypoint and pairs it with the incoming one.
// ----------------------------------------------------------------------------
`default_nettype none

module pcs_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              adv,
	input  wire logic              in_valid,
	input  wire pcs_pkg::in_word_t in_data,
	output logic                   valid_s1,
	output pcs_pkg::front_t        item_s1
);

	typedef enum logic [1:0] {PS_EMPTY, PS_ONE, PS_MANY} ps_t;

	ps_t ps_q;
	logic signed [pcs_pkg::COORD_BITS-1:0] held_x_q;
	logic signed [pcs_pkg::COORD_BITS-1:0] held_y_q;
	logic accept;

	assign accept = in_valid && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ps_q     <= PS_EMPTY;
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= 1'b0;
			if (in_valid) begin
				case (ps_q)
					PS_EMPTY: begin
						// a lone final point is dropped
						ps_q <= in_data.final_point ? PS_EMPTY : PS_ONE;
					end
					PS_ONE, PS_MANY: begin
						valid_s1 <= 1'b1;
						ps_q     <= in_data.final_point ? PS_EMPTY : PS_MANY;
					end
					default: ps_q <= PS_EMPTY;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			held_x_q       <= in_data.point_x;
			held_y_q       <= in_data.point_y;
			item_s1.emit_x <= held_x_q;
			item_s1.emit_y <= held_y_q;
			item_s1.new_x  <= in_data.point_x;
			item_s1.new_y  <= in_data.point_y;
			item_s1.first  <= (ps_q == PS_ONE);
			item_s1.fin    <= in_data.final_point;
			item_s1.dx     <= {in_data.point_x[pcs_pkg::COORD_BITS-1], in_data.point_x}
			                - {held_x_q[pcs_pkg::COORD_BITS-1], held_x_q};
			item_s1.dy     <= {in_data.point_y[pcs_pkg::COORD_BITS-1], in_data.point_y}
			                - {held_y_q[pcs_pkg::COORD_BITS-1], held_y_q};
		end
	end

endmodule

`default_nettype wire

### hdl/pcs_cell.sv
// ----------------------------------------------------------------------------
// Path corner segmenter CORDIC cell
// One vectoring micro-rotation, registered.
// ----------------------------------------------------------------------------
`default_nettype none

module pcs_cell (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           adv,
	input  wire logic [pcs_pkg::STEP_BITS-1:0]  step,
	input  wire logic                           valid_in,
	input  wire pcs_pkg::cord_t                 item_in,
	output logic                                valid_out,
	output pcs_pkg::cord_t                      item_out
);

	logic signed [pcs_pkg::DP_BITS-1:0] xs;
	logic signed [pcs_pkg::DP_BITS-1:0] ys;
	logic [pcs_pkg::ACC_BITS-1:0]       ang;
	pcs_pkg::cord_t                     nxt;

	always_comb begin
		xs  = item_in.cx >>> step;
		ys  = item_in.cy >>> step;
		ang = pcs_pkg::atan_entry(step);
		nxt = item_in;
		// rotate toward the x axis
		if (!item_in.cy[pcs_pkg::DP_BITS-1]) begin
			nxt.cx = item_in.cx + ys;
			nxt.cy = item_in.cy - xs;
			nxt.cz = item_in.cz + ang;
		end else begin
			nxt.cx = item_in.cx - ys;
			nxt.cy = item_in.cy + xs;
			nxt.cz = item_in.cz - ang;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_out <= 1'b0;
		end else if (adv) begin
			valid_out <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_out <= nxt;
		end
	end

endmodule

`default_nettype wire

### hdl/pcs_cordic.sv
// ----------------------------------------------------------------------------
// Path corner segmenter heading unit
// Pre-rotation, a row of CORDIC cells and rounding to a binary angle.
// ----------------------------------------------------------------------------
`default_nettype none

module pcs_cordic (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             adv,
	input  wire logic             valid_in,
	input  wire pcs_pkg::front_t  item_in,
	output logic                  valid_out,
	output pcs_pkg::hdg_t         item_out
);

	logic                 valid_s2;
	pcs_pkg::cord_t       item_s2;
	logic                 cell_v [pcs_pkg::CORDIC_STEPS+1];
	pcs_pkg::cord_t       cell_d [pcs_pkg::CORDIC_STEPS+1];

	logic signed [pcs_pkg::DP_BITS-1:0] gx;
	logic signed [pcs_pkg::DP_BITS-1:0] gy;
	logic [pcs_pkg::ACC_BITS-1:0]       zr;
	pcs_pkg::cord_t                     tail;

	// scale by the guard factor and fold the left half plane
	always_comb begin
		gx = pcs_pkg::DP_BITS'(item_in.dx) <<< pcs_pkg::GUARD_SHIFT;
		gy = pcs_pkg::DP_BITS'(item_in.dy) <<< pcs_pkg::GUARD_SHIFT;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s2.emit_x <= item_in.emit_x;
			item_s2.emit_y <= item_in.emit_y;
			item_s2.new_x  <= item_in.new_x;
			item_s2.new_y  <= item_in.new_y;
			item_s2.first  <= item_in.first;
			item_s2.fin    <= item_in.fin;
			item_s2.zero   <= (item_in.dx == '0) && (item_in.dy == '0);
			if (item_in.dx[pcs_pkg::DIFF_BITS-1]) begin
				item_s2.cx <= -gx;
				item_s2.cy <= -gy;
				item_s2.cz <= pcs_pkg::HALF_TURN;
			end else begin
				item_s2.cx <= gx;
				item_s2.cy <= gy;
				item_s2.cz <= '0;
			end
		end
	end

	assign cell_v[0] = valid_s2;
	assign cell_d[0] = item_s2;

	for (genvar i = 0; i < pcs_pkg::CORDIC_STEPS; i++) begin : g_cell
		pcs_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.adv       (adv),
			.step      (pcs_pkg::STEP_BITS'(i)),
			.valid_in  (cell_v[i]),
			.item_in   (cell_d[i]),
			.valid_out (cell_v[i+1]),
			.item_out  (cell_d[i+1])
		);
	end

	assign tail = cell_d[pcs_pkg::CORDIC_STEPS];
	assign zr   = tail.cz + pcs_pkg::ROUND_ADD;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_out <= 1'b0;
		end else if (adv) begin
			valid_out <= cell_v[pcs_pkg::CORDIC_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_out.emit_x  <= tail.emit_x;
			item_out.emit_y  <= tail.emit_y;
			item_out.new_x   <= tail.new_x;
			item_out.new_y   <= tail.new_y;
			item_out.first   <= tail.first;
			item_out.fin     <= tail.fin;
			// a zero-length step points along the x axis
			item_out.heading <= tail.zero ? '0
			                  : zr[pcs_pkg::ACC_BITS-1 -: pcs_pkg::ANGLE_BITS];
		end
	end

endmodule

`default_nettype wire

### hdl/pcs_emit.sv
// ----------------------------------------------------------------------------
// Path corner segmenter result stage
// Corner test, segment count and the two-word output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pcs_emit (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic [pcs_pkg::THRESH_BITS-1:0]   threshold,
	input  wire logic                              valid_in,
	input  wire pcs_pkg::hdg_t                     item_in,
	input  wire logic                              out_stall,
	output logic                                   out_valid,
	output pcs_pkg::out_word_t                     out_data,
	output pcs_pkg::emit_status_t                  status
);

	logic [pcs_pkg::ANGLE_BITS-1:0]   head_q;
	logic [pcs_pkg::SEGMENT_BITS-1:0] seg_q;
	logic                             pend_valid_q;
	pcs_pkg::out_word_t               pend_q;

	logic [pcs_pkg::ANGLE_BITS-1:0]   diff;
	logic [pcs_pkg::ANGLE_BITS-1:0]   mag;
	logic                             corner;
	logic [pcs_pkg::SEGMENT_BITS-1:0] seg_next;
	pcs_pkg::out_word_t               word_a;
	pcs_pkg::out_word_t               word_b;
	logic                             out_acc;
	logic                             take;
	logic                             load;

	always_comb begin
		diff     = head_q - item_in.heading;
		mag      = diff[pcs_pkg::ANGLE_BITS-1] ? (~diff + 1'b1) : diff;
		corner   = !item_in.first &&
		           (pcs_pkg::CMP_BITS'(mag) > pcs_pkg::CMP_BITS'(threshold));
		seg_next = seg_q + pcs_pkg::SEGMENT_BITS'(corner);

		word_a.out_x         = item_in.emit_x;
		word_a.out_y         = item_in.emit_y;
		word_a.segment_index = seg_q;
		word_a.ends_segment  = corner;
		word_a.path_done     = 1'b0;
		word_a.run_last      = !item_in.fin;

		word_b.out_x         = item_in.new_x;
		word_b.out_y         = item_in.new_y;
		word_b.segment_index = seg_next;
		word_b.ends_segment  = 1'b1;
		word_b.path_done     = 1'b1;
		word_b.run_last      = 1'b1;
	end

	assign out_acc = out_valid && !out_stall;
	assign take    = !out_valid || (out_acc && !pend_valid_q);
	assign load    = valid_in && take;

	assign status.take       = take;
	assign status.pend_valid = pend_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid    <= 1'b0;
			pend_valid_q <= 1'b0;
			head_q       <= '0;
			seg_q        <= '0;
		end else if (load) begin
			out_valid    <= 1'b1;
			pend_valid_q <= item_in.fin;
			if (item_in.fin) begin
				// path closed: start the next one empty
				head_q <= '0;
				seg_q  <= '0;
			end else begin
				head_q <= item_in.heading;
				seg_q  <= seg_next;
			end
		end else if (out_acc) begin
			if (pend_valid_q) begin
				pend_valid_q <= 1'b0;
			end else begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_data <= word_a;
			pend_q   <= word_b;
		end else if (out_acc && pend_valid_q) begin
			out_data <= pend_q;
		end
	end

endmodule

`default_nettype wire

### hdl/path_corner_segmenter.sv
// ----------------------------------------------------------------------------
// Path corner segmenter
// Splits a waypoint stream into segments at sharp heading changes.
// ----------------------------------------------------------------------------
// A waypoint is taken every cycle while in_stall is low. Each point is paired
// with the one before it; the heading of that step goes through a row of 28
// CORDIC cells, so a point's word appears only after the point that follows it
// is taken. The first point of a path gives no word, every later point gives
// one word for the point before it, and the final point gives a second word of
// its own, which waits as the pending word behind the single output register.
// in_stall rises only when a finished pair is waiting at the end of the CORDIC
// row and the output register cannot take it. The corner threshold is written
// through cfg_wr_en/cfg_wr_data; the user must write it only while the block
// is idle, and the block itself does not enforce this.
`default_nettype none

module path_corner_segmenter (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_wr_en,
	input  wire logic [pcs_pkg::THRESH_BITS-1:0]    cfg_wr_data,
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire pcs_pkg::in_word_t                  in_data,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output pcs_pkg::out_word_t                      out_data
);

	logic [pcs_pkg::THRESH_BITS-1:0] thresh_q;
	logic                            adv;
	logic                            valid_s1;
	pcs_pkg::front_t                 item_s1;
	logic                            hdg_valid;
	pcs_pkg::hdg_t                   hdg_item;
	pcs_pkg::emit_status_t           emit_st;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= pcs_pkg::THRESH_RESET;
		end else if (cfg_wr_en) begin
			thresh_q <= cfg_wr_data;
		end
	end

	// hold the whole row while a finished pair cannot be taken
	assign adv      = !(hdg_valid && !emit_st.take);
	assign in_stall = !adv;

	pcs_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (in_valid),
		.in_data  (in_data),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	pcs_cordic u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.valid_in  (valid_s1),
		.item_in   (item_s1),
		.valid_out (hdg_valid),
		.item_out  (hdg_item)
	);

	pcs_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.threshold (thresh_q),
		.valid_in  (hdg_valid),
		.item_in   (hdg_item),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_data  (out_data),
		.status    (emit_st)
	);

	a_pend_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		emit_st.pend_valid |-> out_valid)
		else $error("pending word without a word on the output");

	a_second_word: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !out_data.run_last) |=> out_valid)
		else $error("second word of a final point went missing");

	a_done_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.path_done) |-> (out_data.ends_segment && out_data.run_last))
		else $error("final word does not close its segment");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (hdg_valid && out_valid))
		else $error("input stalled with no word waiting");

endmodule

`default_nettype wire

### verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Path corner segmenter testbench
// Streams waypoint paths through the segmenter under random idling on both
// sides and checks every output word against a cycle-free predictor of the
// heading, corner and segment-numbering behavior.
// ----------------------------------------------------------------------------

module testbench;

	import pcs_pkg::*;

	typedef enum int {PATH_EMPTY, PATH_ONE, PATH_RUNNING} path_fill_t;

	localparam int SETTLE_CYCLES = 64;
	localparam int REPORT_CAP    = 50;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_wr_en = 1'b0;
	logic [THRESH_BITS-1:0] cfg_wr_data = '0;
	logic                   in_valid = 1'b0;
	logic                   in_stall;
	in_word_t               in_data = '0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	out_word_t              out_data;

	path_corner_segmenter dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_data    (out_data)
	);

	always #1 clk = ~clk;

	// arctangent of 2^-i in units of 2^-32 turn
	logic [31:0] atan_steps [0:27] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
		32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
		32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
		32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
		32'h00000014, 32'h0000000A, 32'h00000005
	};

	// predictor state
	logic [THRESH_BITS-1:0]       corner_limit = THRESH_RESET;
	logic signed [COORD_BITS-1:0] prior_x = '0;
	logic signed [COORD_BITS-1:0] prior_y = '0;
	logic [ANGLE_BITS-1:0]        prior_heading = '0;
	path_fill_t                   path_fill = PATH_EMPTY;
	logic [SEGMENT_BITS-1:0]      segment_now = '0;

	in_word_t  pending_points [$];
	out_word_t awaited_words [$];

	int  points_queued = 0;
	int  waypoints_taken = 0;
	int  words_matched = 0;
	int  corners_found = 0;
	int  paths_closed = 0;
	int  threshold_writes = 0;
	int  errors = 0;
	int  send_gap = 0;
	bit  send_burst = 1'b0;
	int  stall_left = 0;
	int  long_hold = 0;
	bit  hold_off_req = 1'b0;
	bit  recv_calm = 1'b0;

	// ------------------------------------------------------------------
	// prediction
	// ------------------------------------------------------------------
	function automatic logic [ANGLE_BITS-1:0] step_heading(longint dx, longint dy);
		longint      vx, vy, sx, sy;
		logic [31:0] acc;
		if (dx == 0 && dy == 0)
			return '0;
		vx = dx * 256;
		vy = dy * 256;
		acc = '0;
		if (vx < 0) begin
			vx = -vx;
			vy = -vy;
			acc = 32'h8000_0000;
		end
		for (int i = 0; i < 28; i++) begin
			sx = vx >>> i;
			sy = vy >>> i;
			if (vy >= 0) begin
				vx = vx + sy;
				vy = vy - sx;
				acc = acc + atan_steps[i];
			end else begin
				vx = vx - sy;
				vy = vy + sx;
				acc = acc - atan_steps[i];
			end
		end
		acc = acc + (32'd1 << (31 - ANGLE_BITS));
		return acc[31 -: ANGLE_BITS];
	endfunction

	function automatic void expect_word(logic signed [COORD_BITS-1:0] x,
			logic signed [COORD_BITS-1:0] y, logic ends, logic done, logic last);
		out_word_t w;
		w.out_x         = x;
		w.out_y         = y;
		w.segment_index = segment_now;
		w.ends_segment  = ends;
		w.path_done     = done;
		w.run_last      = last;
		awaited_words.insert(awaited_words.size(), w);
	endfunction

	function automatic void forget_path();
		prior_x       = '0;
		prior_y       = '0;
		prior_heading = '0;
		path_fill     = PATH_EMPTY;
		segment_now   = '0;
	endfunction

	function automatic void track_waypoint(in_word_t p);
		logic [ANGLE_BITS-1:0]        h_out;
		logic signed [ANGLE_BITS-1:0] turn;
		int                           turn_mag;
		logic                         corner;
		if (path_fill == PATH_EMPTY) begin
			if (p.final_point) begin
				forget_path();
			end else begin
				prior_x   = p.point_x;
				prior_y   = p.point_y;
				path_fill = PATH_ONE;
			end
			return;
		end
		h_out = step_heading(longint'(p.point_x) - longint'(prior_x),
			longint'(p.point_y) - longint'(prior_y));
		if (path_fill == PATH_ONE) begin
			expect_word(prior_x, prior_y, 1'b0, 1'b0, !p.final_point);
		end else begin
			turn = prior_heading - h_out;
			turn_mag = (turn < 0) ? -int'(turn) : int'(turn);
			corner = turn_mag > int'(corner_limit);
			expect_word(prior_x, prior_y, corner, 1'b0, !p.final_point);
			if (corner) begin
				segment_now = segment_now + 1'b1;
				corners_found++;
			end
		end
		if (p.final_point) begin
			expect_word(p.point_x, p.point_y, 1'b1, 1'b1, 1'b1);
			paths_closed++;
			forget_path();
			return;
		end
		prior_x       = p.point_x;
		prior_y       = p.point_y;
		prior_heading = h_out;
		path_fill     = PATH_RUNNING;
	endfunction

	// ------------------------------------------------------------------
	// sender
	// ------------------------------------------------------------------
	function automatic int idle_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				track_waypoint(in_data);
				waypoints_taken++;
				if ($urandom_range(0, 199) == 0)
					send_burst = !send_burst;
			end
			// hold a stalled word as it is
			if (!(in_valid && in_stall)) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (pending_points.size() > 0) begin
					in_valid <= 1'b1;
					in_data <= pending_points.pop_front();
					send_gap = send_burst ? 0 : idle_length();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// receiver stall, with one long hold-off on request
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (hold_off_req) begin
			hold_off_req = 1'b0;
			long_hold = 500;
		end
		if (long_hold > 0) begin
			long_hold--;
			out_stall <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else begin
			if ($urandom_range(0, 299) == 0)
				recv_calm = !recv_calm;
			if (!recv_calm && $urandom_range(0, 99) < 25) begin
				stall_left = idle_length();
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// checker
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		out_word_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (awaited_words.size() == 0) begin
				errors++;
				if (errors <= REPORT_CAP)
					$display("%0t: unexpected x=%0d y=%0d seg=%0d end=%b done=%b last=%b",
						$time, out_data.out_x, out_data.out_y, out_data.segment_index,
						out_data.ends_segment, out_data.path_done, out_data.run_last);
			end else begin
				want = awaited_words.pop_front();
				if (out_data !== want) begin
					errors++;
					if (errors <= REPORT_CAP) begin
						$display("%0t: expected x=%0d y=%0d seg=%0d end=%b done=%b last=%b",
							$time, want.out_x, want.out_y, want.segment_index,
							want.ends_segment, want.path_done, want.run_last);
						$display("%0t:      got x=%0d y=%0d seg=%0d end=%b done=%b last=%b",
							$time, out_data.out_x, out_data.out_y,
							out_data.segment_index, out_data.ends_segment,
							out_data.path_done, out_data.run_last);
					end
				end else begin
					words_matched++;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------
	task automatic queue_point(int x, int y, bit fin);
		in_word_t p;
		p.point_x     = COORD_BITS'(x);
		p.point_y     = COORD_BITS'(y);
		p.final_point = fin;
		pending_points.insert(pending_points.size(), p);
		points_queued++;
	endtask

	function automatic int wrap_coord(int v);
		logic signed [COORD_BITS-1:0] c;
		c = COORD_BITS'(v);
		return int'(c);
	endfunction

	function automatic int any_coord();
		return int'($urandom_range(0, 32'hFF_FFFF)) - 32'sd8388608;
	endfunction

	task automatic queue_path(int len);
		int px, py, sx, sy, span, r, t, jx, jy;
		span = 1 << $urandom_range(0, 20);
		px = any_coord();
		py = any_coord();
		if ($urandom_range(0, 3) != 0) begin
			px = px >>> $urandom_range(2, 20);
			py = py >>> $urandom_range(2, 20);
		end
		sx = int'($urandom_range(0, 2 * span)) - span;
		sy = int'($urandom_range(0, 2 * span)) - span;
		for (int k = 0; k < len; k++) begin
			if (k > 0) begin
				r = $urandom_range(0, 99);
				if (r < 45) begin
					// keep heading, with a little jitter
					jx = (sx < 0 ? -sx : sx) / 8;
					jy = (sy < 0 ? -sy : sy) / 8;
					sx = sx + int'($urandom_range(0, 2 * jx)) - jx;
					sy = sy + int'($urandom_range(0, 2 * jy)) - jy;
				end else if (r < 65) begin
					span = 1 << $urandom_range(0, 20);
					sx = int'($urandom_range(0, 2 * span)) - span;
					sy = int'($urandom_range(0, 2 * span)) - span;
				end else if (r < 72) begin
					sx = -sx;
					sy = -sy;
				end else if (r < 87) begin
					t = sx;
					sx = -sy;
					sy = t;
				end
				if (r >= 72 && r < 77) begin
					// repeated point: no move
				end else if (r >= 92) begin
					px = any_coord();
					py = any_coord();
				end else begin
					px = wrap_coord(px + sx);
					py = wrap_coord(py + sy);
				end
			end
			queue_point(px, py, k == len - 1);
		end
	endtask

	task automatic queue_random(int count);
		int goal, r;
		goal = points_queued + count;
		while (points_queued < goal) begin
			r = $urandom_range(0, 99);
			if (r < 8)
				queue_path(1);
			else if (r < 85)
				queue_path($urandom_range(2, 12));
			else if (r < 97)
				queue_path($urandom_range(13, 40));
			else
				queue_path($urandom_range(41, 120));
		end
	endtask

	task automatic settle();
		while (pending_points.size() > 0 || in_valid || awaited_words.size() > 0)
			@(negedge clk);
		// a point with no word of its own may still be in flight
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_threshold(logic [THRESH_BITS-1:0] v);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		corner_limit = v;
		threshold_writes++;
		@(negedge clk);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// single-point path: nothing comes out
		queue_point(5, 5, 1'b1);
		// two points: the origin and a corner of the coordinate range
		queue_point(0, 0, 1'b0);
		queue_point(-8388608, 8388607, 1'b1);
		// around the corners of the coordinate range, with a repeated point
		queue_point(-8388608, -8388608, 1'b0);
		queue_point(8388607, -8388608, 1'b0);
		queue_point(8388607, 8388607, 1'b0);
		queue_point(8388607, 8388607, 1'b0);
		queue_point(0, 8388607, 1'b0);
		queue_point(-8388608, 8388607, 1'b0);
		queue_point(-8388608, 0, 1'b1);
		// gentle bends, no corner
		queue_point(0, 0, 1'b0);
		queue_point(100, 0, 1'b0);
		queue_point(200, 10, 1'b0);
		queue_point(300, 10, 1'b1);
		// straight back
		queue_point(0, 0, 1'b0);
		queue_point(50, 0, 1'b0);
		queue_point(0, 0, 1'b1);
		// unit square
		queue_point(1, 1, 1'b0);
		queue_point(2, 1, 1'b0);
		queue_point(2, 2, 1'b0);
		queue_point(1, 2, 1'b0);
		queue_point(1, 1, 1'b1);

		settle();
		write_threshold(THRESH_BITS'(32767));
		// only a full reversal can split here
		queue_point(0, 0, 1'b0);
		queue_point(7, 3, 1'b0);
		queue_point(0, 0, 1'b0);
		queue_point(7, 3, 1'b1);
		queue_random(250);

		settle();
		write_threshold('0);
		// zigzag: every interior point is a corner
		for (int k = 0; k < 60; k++)
			queue_point((k % 2) * 1000, 0, k == 59);
		queue_random(140);

		settle();
		write_threshold(THRESH_BITS'($urandom_range(1, 32766)));
		queue_random(300);
		@(negedge clk);
		hold_off_req = 1'b1;

		settle();
		write_threshold(THRESH_RESET);
		queue_random(350);

		settle();
		write_threshold(THRESH_BITS'(1));
		queue_random(150);

		settle();
		write_threshold(THRESH_BITS'(16384));
		queue_random(200);

		settle();
		$display("run: %0d waypoints in %0d paths, %0d words checked, %0d corners",
			waypoints_taken, paths_closed, words_matched, corners_found);
		$display("run: %0d threshold settings, %0d errors (first %0d shown)",
			threshold_writes, errors, REPORT_CAP);
		if (errors == 0 && awaited_words.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#100_000_000;
		$display("timeout with %0d words still awaited", awaited_words.size());
		$display("tb: failure");
		$finish;
	end

endmodule
